[rtl/core/lltn_pkg.sv]
`default_nettype none

package lltn_pkg;

	localparam int CORDIC_ITER_DEF = 32;
	localparam int MATRIX_FRAC_DEF = 30;
	localparam int NEWTON_STEPS    = 4;

	localparam int LON_W  = 33;
	localparam int LAT_W  = 31;
	localparam int ALT_W  = 28;
	localparam int OUT_W  = 35;
	localparam int IDX_W  = 2;
	localparam int CFG_W  = 33;
	localparam int IN_TDATA_W  = 96;
	localparam int OUT_TDATA_W = 112;

	localparam logic [IDX_W-1:0] REG_ORIGIN_LON = 2'd0;
	localparam logic [IDX_W-1:0] REG_ORIGIN_LAT = 2'd1;
	localparam logic [IDX_W-1:0] REG_ORIGIN_ALT = 2'd2;

	typedef logic signed [63:0]  w64_t;
	typedef logic signed [127:0] w128_t;

	localparam w64_t ONE_Q60   = 64'sh1000_0000_0000_0000;
	localparam w64_t THREE_Q60 = 64'sh3000_0000_0000_0000;
	localparam logic [63:0] PI_Q61    = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] RAD_SCALE = PI_Q61 / 64'd450000000;
	localparam w64_t CORDIC_K  = 64'sd700114967507363237;
	localparam logic [63:0] E2_Q60 =
		64'd6694380022 * 64'd1152921 + (64'd6694380022 * 64'd504607) / 64'd1000000;
	localparam logic [63:0] A_MM = 64'd6378137000;
	localparam logic signed [34:0] FULL_TURN = 35'sd3600000000;
	localparam logic [31:0] QUARTER_TURN = 32'd900000000;
	localparam logic signed [63:0] OUT_LIMIT = 64'sd16000000000;

	typedef struct packed {
		logic                    tok;
		logic                    last;
		logic signed [ALT_W-1:0] alt;
	} ctl_t;

	typedef struct packed {
		w64_t sb;
		w64_t cb;
		w64_t sl;
		w64_t cl;
	} trig_t;

	typedef struct packed {
		logic signed [65:0] p0;
		logic signed [65:0] p1;
		logic signed [65:0] p2;
		logic signed [65:0] p3;
	} pp_t;

	typedef struct packed {
		logic [1:0]  q;
		logic [29:0] r;
	} quad_t;

	// 64x64 product split into four 33x33 signed partial products
	function automatic pp_t mul_pp(input w64_t a, input w64_t b);
		logic signed [32:0] al, ah, bl, bh;
		pp_t r;
		al = {1'b0, a[31:0]};
		ah = {a[63], a[63:32]};
		bl = {1'b0, b[31:0]};
		bh = {b[63], b[63:32]};
		r.p0 = al * bl;
		r.p1 = ah * bl;
		r.p2 = al * bh;
		r.p3 = ah * bh;
		return r;
	endfunction

	function automatic w128_t pp_sum(input pp_t p);
		w128_t e0, e1, e2, e3;
		e0 = {{62{p.p0[65]}}, p.p0};
		e1 = {{62{p.p1[65]}}, p.p1};
		e2 = {{62{p.p2[65]}}, p.p2};
		e3 = {{62{p.p3[65]}}, p.p3};
		return e0 + (e1 <<< 32) + (e2 <<< 32) + (e3 <<< 64);
	endfunction

	// round half up by s bits, keep a 64 bit window
	function automatic w64_t round_w(input w128_t v, input int s);
		w128_t t;
		t = v + (128'sd1 <<< (s - 1));
		return t[s +: 64];
	endfunction

	function automatic w64_t round_pp(input pp_t p, input int s);
		return round_w(pp_sum(p), s);
	endfunction

	// fold an angle into [0, 360) degrees
	function automatic logic [31:0] fold_angle(input logic signed [34:0] a);
		logic signed [34:0] t;
		t = a;
		if (t < 0) t = t + FULL_TURN;
		if (t < 0) t = t + FULL_TURN;
		if (t >= FULL_TURN) t = t - FULL_TURN;
		return t[31:0];
	endfunction

	function automatic quad_t split_quad(input logic [31:0] a);
		quad_t r;
		logic [31:0] t;
		if (a >= 32'(3 * 64'(QUARTER_TURN))) begin
			r.q = 2'd3;
			t = a - 32'(3 * 64'(QUARTER_TURN));
		end else if (a >= 32'(2 * 64'(QUARTER_TURN))) begin
			r.q = 2'd2;
			t = a - 32'(2 * 64'(QUARTER_TURN));
		end else if (a >= QUARTER_TURN) begin
			r.q = 2'd1;
			t = a - QUARTER_TURN;
		end else begin
			r.q = 2'd0;
			t = a;
		end
		r.r = t[29:0];
		return r;
	endfunction

	// atan(2^-i) in q60 radians, evaluated at elaboration only
	function automatic w64_t atan_q60(input int i);
		w64_t sum;
		w64_t term;
		int   e;
		sum = '0;
		if (i == 0) begin
			sum = w64_t'(PI_Q61 >> 3);
		end else begin
			for (int k = 0; k < 40; k++) begin
				e = 60 - i * (2 * k + 1);
				if (e >= 0) begin
					term = w64_t'((64'd1 << e) / 64'(2 * k + 1));
					if ((k & 1) == 1) sum = sum - term;
					else sum = sum + term;
				end
			end
		end
		return sum;
	endfunction

endpackage

`default_nettype wire

[rtl/core/lla_to_local_neu.sv]
// throughput: one point per cycle unless the output stalls or an origin pass is due;
//   every step of the datapath is a pipeline stage;
//   the 64 bit products take two stages each, the cordic one stage per iteration
// after reset and after every write to an origin register one internal origin pass
//   takes the input slot (s_tready low) and reloads origin and rotation on its way
// reset: arst_n asynchronous, clears valid bits, config to zero, origin state to zero
`default_nettype none

module lla_to_local_neu import lltn_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF,
	parameter int MATRIX_FRAC_BITS  = MATRIX_FRAC_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // point_lon, point_lat, point_alt_mm
	input  logic                   s_tlast,
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // north_mm, east_mm, up_mm
	output logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data
);

	localparam int RW = MATRIX_FRAC_BITS + 2;
	localparam int MS = 60 - MATRIX_FRAC_BITS;

	typedef struct packed {
		ctl_t  ctl;
		trig_t trig;
	} car_t;

	typedef struct packed {
		car_t car;
		w64_t d;
		w64_t y;
	} nw_t;

	function automatic logic signed [RW-1:0] to_mat(input w64_t v);
		w64_t t;
		t = (v + (64'sd1 <<< (MS - 1))) >>> MS;
		return t[RW-1:0];
	endfunction

	function automatic w64_t alt64(input ctl_t c);
		return {{(64 - ALT_W){c.alt[ALT_W-1]}}, c.alt};
	endfunction

	function automatic logic [OUT_W-1:0] sat(input w64_t v);
		w64_t t;
		t = v;
		if (t > OUT_LIMIT) t = OUT_LIMIT;
		if (t < -OUT_LIMIT) t = -OUT_LIMIT;
		return t[OUT_W-1:0];
	endfunction

	logic en;
	logic pending_q;

	logic [LON_W-1:0] cfg_lon_q;
	logic [LAT_W-1:0] cfg_lat_q;
	logic [ALT_W-1:0] cfg_alt_q;

	logic signed [RW-1:0] rot_q [9];
	w64_t                 org_q [3];

	logic [LON_W-1:0] in_lon;
	logic [LAT_W-1:0] in_lat;
	logic [ALT_W-1:0] in_alt;

	logic        v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7, v_s8, v_s9, v_s10;
	logic        v_s11, v_s12, v_s13, v_s14, v_s15, v_s16, v_s17, v_s18, outv_s19;
	ctl_t        ctl_s1, ctl_s2, ctl_s3, ctl_s13, ctl_s14, ctl_s15, ctl_s16, ctl_s17, ctl_s18;
	logic [31:0] alat_s1, alon_s1;
	quad_t       qlat_s2, qlon_s2;
	w64_t        zlat_s3, zlon_s3;
	logic [1:0]  qlat_s3, qlon_s3;

	logic  cv;
	ctl_t  cctl;
	trig_t ctrig;

	car_t car_s4, car_s5, car_s6, car_s7, car_s8, car_s9, car_s10, car_s11, car_s12;
	pp_t  pp_s4, pp_s6;
	w64_t ssq_s5, d_s7;

	logic nv_s  [NEWTON_STEPS][6];
	nw_t  nw_s  [NEWTON_STEPS][6];
	pp_t  npa_s [NEWTON_STEPS];
	pp_t  npc_s [NEWTON_STEPS];
	pp_t  npe_s [NEWTON_STEPS];
	w64_t nyy_s [NEWTON_STEPS];
	w64_t nww_s [NEWTON_STEPS];

	pp_t  ppn_s8, ppcc_s8, ppcs_s8, ppsc_s8, ppss_s8;
	w64_t n_s9, h_s9, cbcl_s9, cbsl_s9, sbcl_s9, sbsl_s9;
	w64_t n_s10;
	pp_t  ppne_s10, ppx_s10, ppy_s10;
	w64_t n_s11, ne2_s11, ex_s11, ey_s11;
	w64_t za_s12, ex_s12, ey_s12;
	pp_t  ppz_s13;
	w64_t ex_s13, ey_s13;
	w64_t ecef_s14 [3];
	w64_t diff_s15 [3];
	pp_t  mpp_s16  [9];
	w128_t mp_s17  [9];
	w64_t row_s18  [3];
	logic [OUT_W-1:0] out_s19 [3];
	logic             last_s19;

	assign en       = m_tready | ~outv_s19;
	assign s_tready = en & ~pending_q;

	// config registers and the origin pass request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_lon_q <= '0;
			cfg_lat_q <= '0;
			cfg_alt_q <= '0;
			pending_q <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ORIGIN_LON: cfg_lon_q <= cfg_data[LON_W-1:0];
					REG_ORIGIN_LAT: cfg_lat_q <= cfg_data[LAT_W-1:0];
					REG_ORIGIN_ALT: cfg_alt_q <= cfg_data[ALT_W-1:0];
					default: ;
				endcase
			end
			if (cfg_we && (cfg_idx == REG_ORIGIN_LON || cfg_idx == REG_ORIGIN_LAT ||
					cfg_idx == REG_ORIGIN_ALT))
				pending_q <= 1'b1;
			else if (en)
				pending_q <= 1'b0;
		end
	end

	assign in_lon = pending_q ? cfg_lon_q : s_tdata[LON_W-1:0];
	assign in_lat = pending_q ? cfg_lat_q : s_tdata[LON_W +: LAT_W];
	assign in_alt = pending_q ? cfg_alt_q : s_tdata[LON_W + LAT_W +: ALT_W];

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1  <= 1'b0; v_s2  <= 1'b0; v_s3  <= 1'b0; v_s4  <= 1'b0; v_s5  <= 1'b0;
			v_s6  <= 1'b0; v_s7  <= 1'b0; v_s8  <= 1'b0; v_s9  <= 1'b0; v_s10 <= 1'b0;
			v_s11 <= 1'b0; v_s12 <= 1'b0; v_s13 <= 1'b0; v_s14 <= 1'b0; v_s15 <= 1'b0;
			v_s16 <= 1'b0; v_s17 <= 1'b0; v_s18 <= 1'b0; outv_s19 <= 1'b0;
		end else if (en) begin
			v_s1  <= pending_q | s_tvalid;
			v_s2  <= v_s1;
			v_s3  <= v_s2;
			v_s4  <= cv;
			v_s5  <= v_s4;
			v_s6  <= v_s5;
			v_s7  <= v_s6;
			v_s8  <= nv_s[NEWTON_STEPS-1][5];
			v_s9  <= v_s8;
			v_s10 <= v_s9;
			v_s11 <= v_s10;
			v_s12 <= v_s11;
			v_s13 <= v_s12;
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
			v_s17 <= v_s16;
			v_s18 <= v_s17;
			// origin passes end here and make no result
			outv_s19 <= v_s18 & ~ctl_s18.tok;
		end
	end

	// angle folding and cordic angle
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s1.tok  <= pending_q;
			ctl_s1.last <= s_tlast & ~pending_q;
			ctl_s1.alt  <= in_alt;
			alon_s1     <= fold_angle({{(35 - LON_W){in_lon[LON_W-1]}}, in_lon});
			alat_s1     <= fold_angle({{(35 - LAT_W){in_lat[LAT_W-1]}}, in_lat});

			ctl_s2  <= ctl_s1;
			qlat_s2 <= split_quad(alat_s1);
			qlon_s2 <= split_quad(alon_s1);

			ctl_s3  <= ctl_s2;
			qlat_s3 <= qlat_s2.q;
			qlon_s3 <= qlon_s2.q;
			zlat_s3 <= w64_t'((64'(qlat_s2.r) * RAD_SCALE) >> 3);
			zlon_s3 <= w64_t'((64'(qlon_s2.r) * RAD_SCALE) >> 3);
		end
	end

	lltn_cordic #(
		.ITER (CORDIC_ITERATIONS)
	) u_cordic (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_ctl    (ctl_s3),
		.in_z_lat  (zlat_s3),
		.in_q_lat  (qlat_s3),
		.in_z_lon  (zlon_s3),
		.in_q_lon  (qlon_s3),
		.out_valid (cv),
		.out_ctl   (cctl),
		.out_trig  (ctrig)
	);

	// d = 1 - e2 * sin^2(lat)
	always_ff @(posedge clk) begin
		if (en) begin
			car_s4.ctl  <= cctl;
			car_s4.trig <= ctrig;
			pp_s4       <= mul_pp(ctrig.sb, ctrig.sb);

			car_s5 <= car_s4;
			ssq_s5 <= round_pp(pp_s4, 60);

			car_s6 <= car_s5;
			pp_s6  <= mul_pp(w64_t'(E2_Q60), ssq_s5);

			car_s7 <= car_s6;
			d_s7   <= ONE_Q60 - round_pp(pp_s6, 60);
		end
	end

	// newton steps for 1/sqrt(d), six stages each
	for (genvar k = 0; k < NEWTON_STEPS; k++) begin : g_nt
		logic vin;
		nw_t  win;

		if (k == 0) begin : g_first
			assign vin = v_s7;
			assign win = '{car: car_s7, d: d_s7, y: ONE_Q60};
		end else begin : g_next
			assign vin = nv_s[k-1][5];
			assign win = nw_s[k-1][5];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				for (int j = 0; j < 6; j++) nv_s[k][j] <= 1'b0;
			end else if (en) begin
				nv_s[k][0] <= vin;
				for (int j = 1; j < 6; j++) nv_s[k][j] <= nv_s[k][j-1];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				nw_s[k][0] <= win;
				npa_s[k]   <= mul_pp(win.y, win.y);

				nw_s[k][1] <= nw_s[k][0];
				nyy_s[k]   <= round_pp(npa_s[k], 60);

				nw_s[k][2] <= nw_s[k][1];
				npc_s[k]   <= mul_pp(nw_s[k][1].d, nyy_s[k]);

				nw_s[k][3] <= nw_s[k][2];
				nww_s[k]   <= THREE_Q60 - round_pp(npc_s[k], 60);

				nw_s[k][4] <= nw_s[k][3];
				npe_s[k]   <= mul_pp(nw_s[k][3].y, nww_s[k]);

				nw_s[k][5].car <= nw_s[k][4].car;
				nw_s[k][5].d   <= nw_s[k][4].d;
				nw_s[k][5].y   <= round_pp(npe_s[k], 61);
			end
		end
	end

	// ecef of the point
	always_ff @(posedge clk) begin
		if (en) begin
			car_s8  <= nw_s[NEWTON_STEPS-1][5].car;
			ppn_s8  <= mul_pp(w64_t'(A_MM), nw_s[NEWTON_STEPS-1][5].y);
			ppcc_s8 <= mul_pp(nw_s[NEWTON_STEPS-1][5].car.trig.cb,
				nw_s[NEWTON_STEPS-1][5].car.trig.cl);
			ppcs_s8 <= mul_pp(nw_s[NEWTON_STEPS-1][5].car.trig.cb,
				nw_s[NEWTON_STEPS-1][5].car.trig.sl);
			ppsc_s8 <= mul_pp(nw_s[NEWTON_STEPS-1][5].car.trig.sb,
				nw_s[NEWTON_STEPS-1][5].car.trig.cl);
			ppss_s8 <= mul_pp(nw_s[NEWTON_STEPS-1][5].car.trig.sb,
				nw_s[NEWTON_STEPS-1][5].car.trig.sl);

			car_s9  <= car_s8;
			n_s9    <= round_pp(ppn_s8, 60);
			h_s9    <= round_pp(ppn_s8, 60) + alt64(car_s8.ctl);
			cbcl_s9 <= round_pp(ppcc_s8, 60);
			cbsl_s9 <= round_pp(ppcs_s8, 60);
			sbcl_s9 <= round_pp(ppsc_s8, 60);
			sbsl_s9 <= round_pp(ppss_s8, 60);

			car_s10  <= car_s9;
			n_s10    <= n_s9;
			ppne_s10 <= mul_pp(n_s9, w64_t'(E2_Q60));
			ppx_s10  <= mul_pp(h_s9, cbcl_s9);
			ppy_s10  <= mul_pp(h_s9, cbsl_s9);

			car_s11 <= car_s10;
			n_s11   <= n_s10;
			ne2_s11 <= round_pp(ppne_s10, 60);
			ex_s11  <= round_pp(ppx_s10, 60);
			ey_s11  <= round_pp(ppy_s10, 60);

			car_s12 <= car_s11;
			za_s12  <= n_s11 - ne2_s11 + alt64(car_s11.ctl);
			ex_s12  <= ex_s11;
			ey_s12  <= ey_s11;

			ctl_s13 <= car_s12.ctl;
			ppz_s13 <= mul_pp(za_s12, car_s12.trig.sb);
			ex_s13  <= ex_s12;
			ey_s13  <= ey_s12;

			ctl_s14     <= ctl_s13;
			ecef_s14[0] <= ex_s13;
			ecef_s14[1] <= ey_s13;
			ecef_s14[2] <= round_pp(ppz_s13, 60);
		end
	end

	// origin state, loaded by the origin pass as it goes by
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) rot_q[i] <= '0;
			for (int i = 0; i < 3; i++) org_q[i] <= '0;
		end else begin
			if (v_s9 && car_s9.ctl.tok) begin
				rot_q[0] <= to_mat(-sbcl_s9);
				rot_q[1] <= to_mat(-sbsl_s9);
				rot_q[2] <= to_mat(car_s9.trig.cb);
				rot_q[3] <= to_mat(-car_s9.trig.sl);
				rot_q[4] <= to_mat(car_s9.trig.cl);
				rot_q[5] <= '0;
				rot_q[6] <= to_mat(cbcl_s9);
				rot_q[7] <= to_mat(cbsl_s9);
				rot_q[8] <= to_mat(car_s9.trig.sb);
			end
			if (v_s14 && ctl_s14.tok) begin
				for (int i = 0; i < 3; i++) org_q[i] <= ecef_s14[i];
			end
		end
	end

	// offset, rotation, rounding and clamp
	always_ff @(posedge clk) begin
		if (en) begin
			ctl_s15 <= ctl_s14;
			for (int i = 0; i < 3; i++) diff_s15[i] <= ecef_s14[i] - org_q[i];

			ctl_s16 <= ctl_s15;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					mpp_s16[r * 3 + c] <= mul_pp(64'(rot_q[r * 3 + c]), diff_s15[c]);
				end
			end

			ctl_s17 <= ctl_s16;
			for (int i = 0; i < 9; i++) mp_s17[i] <= pp_sum(mpp_s16[i]);

			ctl_s18 <= ctl_s17;
			for (int r = 0; r < 3; r++) begin
				row_s18[r] <= round_w(mp_s17[r * 3] + mp_s17[r * 3 + 1] + mp_s17[r * 3 + 2],
					MATRIX_FRAC_BITS);
			end

			last_s19 <= ctl_s18.last;
			for (int r = 0; r < 3; r++) out_s19[r] <= sat(row_s18[r]);
		end
	end

	assign m_tvalid = outv_s19;
	assign m_tlast  = last_s19;
	assign m_tdata  = {{(OUT_TDATA_W - 3 * OUT_W){1'b0}}, out_s19[2], out_s19[1], out_s19[0]};

endmodule

`default_nettype wire

[rtl/core/lltn_cordic.sv]
`default_nettype none

module lltn_cordic import lltn_pkg::*; #(
	parameter int ITER = CORDIC_ITER_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       en,
	input  logic       in_valid,
	input  ctl_t       in_ctl,
	input  w64_t       in_z_lat,
	input  logic [1:0] in_q_lat,
	input  w64_t       in_z_lon,
	input  logic [1:0] in_q_lon,
	output logic       out_valid,
	output ctl_t       out_ctl,
	output trig_t      out_trig
);

	typedef struct packed {
		w64_t s;
		w64_t c;
	} sc_t;

	function automatic sc_t quad_map(input logic [1:0] q, input w64_t x, input w64_t y);
		sc_t r;
		case (q)
			2'd0: begin
				r.s = y;
				r.c = x;
			end
			2'd1: begin
				r.s = x;
				r.c = -y;
			end
			2'd2: begin
				r.s = -y;
				r.c = -x;
			end
			default: begin
				r.s = -x;
				r.c = y;
			end
		endcase
		return r;
	endfunction

	// lane 0 is latitude, lane 1 is longitude
	logic       cv_s [ITER];
	ctl_t       cc_s [ITER];
	w64_t       cx_s [ITER][2];
	w64_t       cy_s [ITER][2];
	w64_t       cz_s [ITER][2];
	logic [1:0] cq_s [ITER][2];

	logic  ov_s;
	ctl_t  oc_s;
	trig_t ot_s;
	sc_t   lat_sc;
	sc_t   lon_sc;

	for (genvar j = 0; j < ITER; j++) begin : g_it
		localparam w64_t ATAN = atan_q60(j);
		logic       vp;
		ctl_t       cp;
		w64_t       xp [2];
		w64_t       yp [2];
		w64_t       zp [2];
		logic [1:0] qp [2];

		if (j == 0) begin : g_first
			assign vp    = in_valid;
			assign cp    = in_ctl;
			assign xp[0] = CORDIC_K;
			assign xp[1] = CORDIC_K;
			assign yp[0] = '0;
			assign yp[1] = '0;
			assign zp[0] = in_z_lat;
			assign zp[1] = in_z_lon;
			assign qp[0] = in_q_lat;
			assign qp[1] = in_q_lon;
		end else begin : g_next
			assign vp    = cv_s[j-1];
			assign cp    = cc_s[j-1];
			assign xp[0] = cx_s[j-1][0];
			assign xp[1] = cx_s[j-1][1];
			assign yp[0] = cy_s[j-1][0];
			assign yp[1] = cy_s[j-1][1];
			assign zp[0] = cz_s[j-1][0];
			assign zp[1] = cz_s[j-1][1];
			assign qp[0] = cq_s[j-1][0];
			assign qp[1] = cq_s[j-1][1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_s[j] <= 1'b0;
			else if (en) cv_s[j] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				cc_s[j] <= cp;
				for (int l = 0; l < 2; l++) begin
					cq_s[j][l] <= qp[l];
					if (zp[l][63]) begin
						cx_s[j][l] <= xp[l] + (yp[l] >>> j);
						cy_s[j][l] <= yp[l] - (xp[l] >>> j);
						cz_s[j][l] <= zp[l] + ATAN;
					end else begin
						cx_s[j][l] <= xp[l] - (yp[l] >>> j);
						cy_s[j][l] <= yp[l] + (xp[l] >>> j);
						cz_s[j][l] <= zp[l] - ATAN;
					end
				end
			end
		end
	end

	assign lat_sc = quad_map(cq_s[ITER-1][0], cx_s[ITER-1][0], cy_s[ITER-1][0]);
	assign lon_sc = quad_map(cq_s[ITER-1][1], cx_s[ITER-1][1], cy_s[ITER-1][1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_s <= 1'b0;
		else if (en) ov_s <= cv_s[ITER-1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			oc_s    <= cc_s[ITER-1];
			ot_s.sb <= lat_sc.s;
			ot_s.cb <= lat_sc.c;
			ot_s.sl <= lon_sc.s;
			ot_s.cl <= lon_sc.c;
		end
	end

	assign out_valid = ov_s;
	assign out_ctl   = oc_s;
	assign out_trig  = ot_s;

endmodule

`default_nettype wire

[rtl/core/lltn_chk.sv]
`default_nettype none

module lltn_chk import lltn_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   s_tready,
	input wire logic                   m_tvalid,
	input wire logic                   m_tready,
	input wire logic [OUT_TDATA_W-1:0] m_tdata,
	input wire logic                   m_tlast,
	input wire logic                   cfg_we,
	input wire logic [IDX_W-1:0]       cfg_idx
);

	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed under stall");

	// every offset is clamped
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata[34:0]) <= 35'sd16000000000) &&
			($signed(m_tdata[34:0]) >= -35'sd16000000000) &&
			($signed(m_tdata[69:35]) <= 35'sd16000000000) &&
			($signed(m_tdata[69:35]) >= -35'sd16000000000) &&
			($signed(m_tdata[104:70]) <= 35'sd16000000000) &&
			($signed(m_tdata[104:70]) >= -35'sd16000000000))
		else $error("offset out of range");

	// no result while in reset
	a_rst: assert property (@(posedge clk) !arst_n |-> !m_tvalid)
		else $error("result during reset");

	// a write to an origin register blocks input for the origin pass
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we && (cfg_idx == REG_ORIGIN_LON || cfg_idx == REG_ORIGIN_LAT ||
			cfg_idx == REG_ORIGIN_ALT) |=> !s_tready)
		else $error("input taken ahead of origin pass");

endmodule

bind lla_to_local_neu lltn_chk u_chk (.*);

`default_nettype wire

[tb/neu_checker.sv]
`timescale 1ns / 100ps

module neu_checker import lltn_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	input  logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,
	input  logic                   s_tlast,
	input  logic                   m_tvalid,
	input  logic                   m_tready,
	input  logic [OUT_TDATA_W-1:0] m_tdata,
	input  logic                   m_tlast,
	input  logic                   cfg_we,
	input  logic [IDX_W-1:0]       cfg_idx,
	input  logic [CFG_W-1:0]       cfg_data,
	output int                     fail_count,
	output int                     pending,
	output int                     n_checked
);

	localparam int  ITER  = 32;
	localparam int  MFRAC = 30;
	localparam longint GAIN_K   = 64'sd700114967507363237;
	localparam longint UNIT_Q60 = 64'sh1000_0000_0000_0000;
	localparam logic [63:0] PI_Q61_C = 64'h6487_ED51_10B4_611A;
	localparam logic [63:0] DEG7_TO_RAD = PI_Q61_C / 64'd450000000;
	localparam longint ECC_SQ =
		64'd6694380022 * 64'd1152921 + (64'd6694380022 * 64'd504607) / 64'd1000000;
	localparam longint SEMI_MAJOR = 64'sd6378137000;
	localparam longint TURN   = 64'sd3600000000;
	localparam longint QUART  = 64'sd900000000;
	localparam longint CLAMP  = 64'sd16000000000;

	typedef struct {
		logic signed [OUT_W-1:0] north;
		logic signed [OUT_W-1:0] east;
		logic signed [OUT_W-1:0] up;
		logic                    last;
	} neu_t;

	neu_t   expected_neu_q[$];
	longint atan_tbl[ITER];
	logic [LON_W-1:0] cfg_lon;
	logic [LAT_W-1:0] cfg_lat;
	logic [ALT_W-1:0] cfg_alt;
	longint org_x, org_y, org_z;
	longint rot[9];

	initial begin
		longint sum, term;
		int e;
		for (int i = 0; i < ITER; i++) begin
			sum = 0;
			if (i == 0) begin
				sum = longint'(PI_Q61_C >> 3);
			end else begin
				for (int k = 0; k < 40; k++) begin
					e = 60 - i * (2 * k + 1);
					if (e >= 0) begin
						term = longint'((64'd1 << e) / 64'(2 * k + 1));
						sum = (k & 1) ? sum - term : sum + term;
					end
				end
			end
			atan_tbl[i] = sum;
		end
	end

	// exact product, rounded half up by s bits, 64 bit window
	function automatic longint mul_round(longint a, longint b, int s);
		logic signed [127:0] pa, pb, p;
		pa = a;
		pb = b;
		p = pa * pb + (128'sd1 <<< (s - 1));
		return p[s +: 64];
	endfunction

	function automatic void sin_cos(input longint ang, output longint s, output longint c);
		longint q, r, x, y, z, dx, dy;
		logic [63:0] zz;
		if (ang < 0) ang += TURN;
		if (ang < 0) ang += TURN;
		if (ang >= TURN) ang -= TURN;
		q = ang / QUART;
		r = ang - q * QUART;
		zz = 64'(r) * DEG7_TO_RAD;
		z = longint'(zz >> 3);
		x = GAIN_K;
		y = 0;
		for (int i = 0; i < ITER; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (z >= 0) begin
				x -= dx; y += dy; z -= atan_tbl[i];
			end else begin
				x += dx; y -= dy; z += atan_tbl[i];
			end
		end
		case (q)
			0: begin s = y;  c = x;  end
			1: begin s = x;  c = -y; end
			2: begin s = -y; c = -x; end
			default: begin s = -x; c = y; end
		endcase
	endfunction

	function automatic void geo_to_ecef(input longint lon, input longint lat, input longint alt,
			output longint ex, output longint ey, output longint ez);
		longint sb, cb, sl, cl, d, y, t, n, h;
		sin_cos(lat, sb, cb);
		sin_cos(lon, sl, cl);
		d = UNIT_Q60 - mul_round(ECC_SQ, mul_round(sb, sb, 60), 60);
		y = UNIT_Q60;
		// newton steps toward 1/sqrt(d)
		for (int k = 0; k < 4; k++) begin
			t = mul_round(d, mul_round(y, y, 60), 60);
			y = mul_round(y, 3 * UNIT_Q60 - t, 61);
		end
		n = mul_round(SEMI_MAJOR, y, 60);
		h = n + alt;
		ex = mul_round(h, mul_round(cb, cl, 60), 60);
		ey = mul_round(h, mul_round(cb, sl, 60), 60);
		ez = mul_round(n - mul_round(n, ECC_SQ, 60) + alt, sb, 60);
	endfunction

	function automatic longint to_mat(longint v);
		return (v + (64'sd1 <<< (59 - MFRAC))) >>> (60 - MFRAC);
	endfunction

	function automatic void rebuild_origin();
		longint lon, lat, sb, cb, sl, cl;
		lon = longint'($signed(cfg_lon));
		lat = longint'($signed(cfg_lat));
		geo_to_ecef(lon, lat, longint'($signed(cfg_alt)), org_x, org_y, org_z);
		sin_cos(lat, sb, cb);
		sin_cos(lon, sl, cl);
		rot[0] = to_mat(-mul_round(sb, cl, 60));
		rot[1] = to_mat(-mul_round(sb, sl, 60));
		rot[2] = to_mat(cb);
		rot[3] = to_mat(-sl);
		rot[4] = to_mat(cl);
		rot[5] = 0;
		rot[6] = to_mat(mul_round(cb, cl, 60));
		rot[7] = to_mat(mul_round(cb, sl, 60));
		rot[8] = to_mat(sb);
	endfunction

	function automatic neu_t predict_neu(logic [IN_TDATA_W-1:0] d, logic last);
		longint px, py, pz, dv[3], v;
		logic signed [127:0] acc, a, b;
		logic signed [OUT_W-1:0] res[3];
		neu_t o;
		geo_to_ecef(longint'($signed(d[LON_W-1:0])),
			longint'($signed(d[LON_W +: LAT_W])),
			longint'($signed(d[LON_W+LAT_W +: ALT_W])), px, py, pz);
		dv[0] = px - org_x;
		dv[1] = py - org_y;
		dv[2] = pz - org_z;
		for (int r = 0; r < 3; r++) begin
			acc = 0;
			for (int j = 0; j < 3; j++) begin
				a = rot[r * 3 + j];
				b = dv[j];
				acc += a * b;
			end
			acc += 128'sd1 <<< (MFRAC - 1);
			v = acc[MFRAC +: 64];
			if (v > CLAMP) v = CLAMP;
			if (v < -CLAMP) v = -CLAMP;
			res[r] = v[OUT_W-1:0];
		end
		o.north = res[0];
		o.east  = res[1];
		o.up    = res[2];
		o.last  = last;
		return o;
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch at %0t: %s got %0d expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	initial begin
		fail_count = 0;
		n_checked = 0;
	end

	assign pending = expected_neu_q.size();

	always @(posedge clk or negedge arst_n) begin
		neu_t w, g;
		if (!arst_n) begin
			cfg_lon = '0;
			cfg_lat = '0;
			cfg_alt = '0;
			rebuild_origin();
			expected_neu_q.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_ORIGIN_LON: cfg_lon = cfg_data[LON_W-1:0];
					REG_ORIGIN_LAT: cfg_lat = cfg_data[LAT_W-1:0];
					REG_ORIGIN_ALT: cfg_alt = cfg_data[ALT_W-1:0];
					default: ;
				endcase
				rebuild_origin();
			end
			if (s_tvalid && s_tready)
				expected_neu_q.push_back(predict_neu(s_tdata, s_tlast));
			if (m_tvalid && m_tready) begin
				if (expected_neu_q.size() == 0) begin
					report_mismatch("result with nothing pending", 0, 0);
				end else begin
					w = expected_neu_q.pop_front();
					g.north = m_tdata[OUT_W-1:0];
					g.east  = m_tdata[OUT_W +: OUT_W];
					g.up    = m_tdata[2*OUT_W +: OUT_W];
					n_checked++;
					if (g.north !== w.north) report_mismatch("north_mm", g.north, w.north);
					if (g.east !== w.east)   report_mismatch("east_mm", g.east, w.east);
					if (g.up !== w.up)       report_mismatch("up_mm", g.up, w.up);
					if (m_tlast !== w.last)  report_mismatch("last_out", m_tlast, w.last);
				end
			end
		end
	end

endmodule

[tb/tb.sv]
`timescale 1ns / 100ps

module tb;
	import lltn_pkg::*;

	localparam logic [IDX_W-1:0] REG_NONE = 2'd3;
	localparam int SETTLE = 90;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic s_tlast = 1'b0;
	logic s_tready;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic m_tlast;
	logic cfg_we = 1'b0;
	logic [IDX_W-1:0] cfg_idx = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	int fail_count, pending, n_checked;
	bit hold_off = 0;
	int burst_left = 0;
	int n_sent = 0;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	lla_to_local_neu DUT (.*);

	neu_checker u_check (.*);

	function automatic longint rand_between(longint lo, longint hi);
		logic [63:0] u;
		u = {$urandom, $urandom};
		return lo + longint'(u % 64'(hi - lo + 1));
	endfunction

	task automatic send_point(longint lon, longint lat, longint alt, bit last);
		if (burst_left == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, ALT_W'(alt), LAT_W'(lat), LON_W'(lon)};
		s_tlast <= last;
		do @(posedge clk); while (!s_tready);
		burst_left--;
		n_sent++;
	endtask

	task automatic write_reg(logic [IDX_W-1:0] idx, longint value);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= CFG_W'(value);
		@(posedge clk);
	endtask

	// only while the pipeline is empty
	task automatic set_origin(longint lon, longint lat, longint alt);
		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		write_reg(REG_ORIGIN_LON, lon);
		write_reg(REG_ORIGIN_LAT, lat);
		write_reg(REG_ORIGIN_ALT, alt);
		write_reg(REG_NONE, rand_between(0, 64'h1_FFFF_FFFF));
		cfg_we <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_point();
		if ($urandom_range(0, 9) == 0)
			// full field width, angles outside the nominal range
			send_point(rand_between(-(64'sd1 <<< 32), (64'sd1 <<< 32) - 1),
				rand_between(-(64'sd1 <<< 30), (64'sd1 <<< 30) - 1),
				rand_between(-(64'sd1 <<< 27), (64'sd1 <<< 27) - 1), $urandom_range(0, 1));
		else
			send_point(rand_between(-1800000000, 3599999999),
				rand_between(-900000000, 900000000),
				rand_between(-1000000, 100000000), $urandom_range(0, 7) == 0);
	endtask

	// receiver stall pattern, plus one long hold-off on request
	initial begin
		int mode;
		forever begin
			if (hold_off) begin
				m_tready <= 1'b0;
				repeat (300) @(posedge clk);
				hold_off = 0;
			end
			mode = $urandom_range(0, 2);
			repeat ($urandom_range(5, 60)) begin
				case (mode)
					0: m_tready <= 1'b1;
					1: m_tready <= $urandom_range(0, 1);
					default: m_tready <= ($urandom_range(0, 4) == 0);
				endcase
				@(posedge clk);
			end
		end
	end

	initial begin
		#2000000;
		$display("status: fail");
		$finish;
	end

	initial begin
		longint dlon[6] = '{-1800000000, 3599999999, 0, 900000000, 1799999999, -1};
		longint dlat[5] = '{-900000000, 900000000, 0, 450000000, -1};
		longint dalt[4] = '{-1000000, 100000000, 0, 1};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int ph = 0; ph < 7; ph++) begin
			case (ph)
				0: set_origin(0, 0, 0);
				1: set_origin(-1800000000, -900000000, -1000000);
				2: set_origin(3599999999, 900000000, 100000000);
				default: set_origin(rand_between(-1800000000, 3599999999),
					rand_between(-900000000, 900000000),
					rand_between(-1000000, 100000000));
			endcase
			if (ph == 0) begin
				for (int i = 0; i < 6; i++)
					send_point(dlon[i], dlat[i % 5], dalt[i % 4], i == 5);
				for (int i = 0; i < 5; i++)
					send_point(dlon[(i + 2) % 6], dlat[i], dalt[(i + 1) % 4], 0);
				send_point(-(64'sd1 <<< 32), -(64'sd1 <<< 30), -(64'sd1 <<< 27), 1);
				send_point((64'sd1 <<< 32) - 1, (64'sd1 <<< 30) - 1, (64'sd1 <<< 27) - 1, 0);
				send_point(-1800000000, 900000000, 100000000, 1);
				send_point(3599999999, -900000000, -1000000, 0);
			end
			if (ph == 1) hold_off = 1;
			repeat (200) random_point();
		end

		s_tvalid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		$display("sent %0d points over 7 origin settings, %0d results checked",
			n_sent, n_checked);
		$display("origins included both range extremes and an unused register index");
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
